// ----- src/naive_bayes_vote_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the vote decoder checkers
// Immediate-consequence and next-cycle property forms, both reset-gated.
// ----------------------------------------------------------------------------
`ifndef NAIVE_BAYES_VOTE_DECODER_ASSERT_SVH
`define NAIVE_BAYES_VOTE_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NBVD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NBVD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/nbvd_pkg.sv -----
// ----------------------------------------------------------------------------
// nbvd_pkg
// Shared codes and fixed-point constants for the naive Bayes vote decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nbvd_pkg;

  // Request kinds (carried on in_tuser)
  localparam logic [1:0] OP_WRITE_PROB  = 2'd0;
  localparam logic [1:0] OP_WRITE_PRIOR = 2'd1;
  localparam logic [1:0] OP_CLASSIFY    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_CLASS_COUNT      = 2'd0;
  localparam logic [1:0] CFG_CLASSIFIER_COUNT = 2'd1;
  localparam logic [1:0] CFG_STEP_LIMIT       = 2'd2;
  localparam logic [1:0] CFG_TEST_MODE        = 2'd3;

  // Fixed-point units
  localparam logic [16:0] ONE_Q16 = 17'h1_0000;
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  // Stream packing
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 40;

  typedef logic [16:0] prob_t;
  typedef logic [32:0] score_t;

endpackage

`default_nettype wire

// ----- src/naive_bayes_vote_decoder.sv -----
// ----------------------------------------------------------------------------
// naive_bayes_vote_decoder
// Combines binary classifier answers into a class decision by naive Bayes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per handshake. in_tuser carries the request kind:
//           table probability write, class prior write or classify.
//           Writes complete in the accept cycle and give no result.
//   out_* : one result per classify request: winning class and its Q1.32
//           score, held in an output register until taken.
//   cfg_* : register writes, always ready; issue only while the block idles.
// Throughput:
//   A classify request walks the probability RAM one classifier per cycle.
//   Each class goes through read pipeline fill and drain, prior multiply
//   and compare, one class after another.
//   The single RAM read port and the shared 33x17 multiplier set this.
//   in_tready is low from classify accept until the result is registered.
// Reset: control and config registers go to defaults (2 classes, one
//   classifier, step limit 1, test mode off). Tables are not cleared; they
//   must be written before use.
// Back-pressure: a finished result waits in the output register; new
//   requests are still taken. A second result waits until the first leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module naive_bayes_vote_decoder
  import nbvd_pkg::*;
#(
  parameter int MAX_CLASSES     = 8,
  parameter int MAX_CLASSIFIERS = 32,
  parameter int MAX_STEPS       = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // in_tdata, LSB first: class_index[3], classifier_index[5], step_index[6],
  //   prob_value[17], answer_bits[32], steps_used[7], zero pad[2]
  input  wire logic                   in_tvalid,
  output      logic                   in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: operation[2]
  input  wire logic [1:0]             in_tuser,
  // out_tdata, LSB first: best_class[3], best_score[33], zero pad[4]
  output      logic                   out_tvalid,
  input  wire logic                   out_tready,
  output      logic [OUT_TDATA_W-1:0] out_tdata,
  // configuration writes
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [6:0]             cfg_data
);

  localparam int DEPTH = MAX_CLASSES * MAX_CLASSIFIERS * MAX_STEPS;
  localparam int TAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_CLASSES);
  localparam int KCW   = $clog2(MAX_CLASSIFIERS + 1);
  localparam int KW    = (MAX_CLASSIFIERS > 1) ? $clog2(MAX_CLASSIFIERS) : 1;
  localparam int SW    = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int ROW   = MAX_CLASSIFIERS * MAX_STEPS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_PRIOR = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // Request field unpack
  logic [1:0]  f_op;
  logic [2:0]  f_cls;
  logic [4:0]  f_clf;
  logic [5:0]  f_stp;
  prob_t       f_prob;
  logic [31:0] f_ans;
  logic [6:0]  f_req;

  assign f_op   = in_tuser;
  assign f_cls  = in_tdata[2:0];
  assign f_clf  = in_tdata[7:3];
  assign f_stp  = in_tdata[13:8];
  assign f_prob = in_tdata[30:14];
  assign f_ans  = in_tdata[62:31];
  assign f_req  = in_tdata[69:63];

  // Config registers
  logic [3:0] class_count_r;
  logic [5:0] classifier_count_r;
  logic [6:0] step_limit_r;
  logic       test_mode_r;

  // Control
  logic [2:0]     state_r, state_nxt;
  logic [CW-1:0]  cls_r, cls_nxt;
  logic [CW-1:0]  nc_m1_r, nc_m1_nxt;
  logic [KCW-1:0] k_rd_r, k_rd_nxt;
  logic [KCW-1:0] nk_r, nk_nxt;
  logic           rd_v_r, rd_v_nxt;
  logic           out_v_r, out_v_nxt;

  // Datapath
  logic [31:0]    ans_r, ans_nxt;
  logic [31:0]    ans_w_r, ans_w_nxt;
  logic           said_r, said_nxt;
  logic [SW-1:0]  col_r, col_nxt;
  score_t         prod_r, prod_nxt;
  score_t         best_r, best_nxt;
  logic [CW-1:0]  best_idx_r, best_idx_nxt;
  logic [2:0]     out_class_r, out_class_nxt;
  score_t         out_score_r, out_score_nxt;

  // Memories
  prob_t tbl_mem [DEPTH];
  prob_t prior_mem [MAX_CLASSES];
  prob_t tbl_q;
  prob_t prior_q;

  logic           in_acc;
  logic           tbl_we, prior_we, tbl_re;
  logic [TAW-1:0] tbl_waddr, tbl_raddr;
  prob_t          prob_sat;

  // Clamp helpers for a classify request
  logic [6:0]     lim7, num7;

  // Shared multiplier
  prob_t          factor;
  logic [49:0]    mul_full;
  logic           better;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0, out_score_r, out_class_r};

  // Write path
  assign prob_sat = (f_prob > ONE_Q16) ? ONE_Q16 : f_prob;
  assign tbl_we   = in_acc && (f_op == OP_WRITE_PROB) &&
                    (int'(f_cls) < MAX_CLASSES) && (int'(f_clf) < MAX_CLASSIFIERS) &&
                    (int'(f_stp) < MAX_STEPS);
  assign prior_we = in_acc && (f_op == OP_WRITE_PRIOR) && (int'(f_cls) < MAX_CLASSES);
  assign tbl_waddr = TAW'(TAW'(f_cls) * TAW'(ROW)) + TAW'(TAW'(f_clf) * TAW'(MAX_STEPS)) +
                     TAW'(f_stp);

  // Read path: entry (class, classifier, column)
  assign tbl_re    = (state_r == S_MUL) && (k_rd_r < nk_r);
  assign tbl_raddr = TAW'(TAW'(cls_r) * TAW'(ROW)) +
                     TAW'(TAW'(k_rd_r[KW-1:0]) * TAW'(MAX_STEPS)) + TAW'(col_r);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= prob_sat;
    end
    if (tbl_re) begin
      tbl_q <= tbl_mem[tbl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (prior_we) begin
      prior_mem[f_cls[CW-1:0]] <= prob_sat;
    end
    prior_q <= prior_mem[cls_r];
  end

  // Answer 1 uses one minus the stored probability
  assign factor   = (state_r == S_PRIOR) ? prior_q :
                    (said_r ? prob_t'(ONE_Q16 - tbl_q) : tbl_q);
  assign mul_full = 50'(prod_r) * 50'(factor);
  assign better   = (cls_r == '0) || (prod_r > best_r);

  // Step clamp
  always_comb begin
    if (step_limit_r == 7'd0) begin
      lim7 = 7'd1;
    end else if (int'(step_limit_r) > MAX_STEPS) begin
      lim7 = 7'(MAX_STEPS);
    end else begin
      lim7 = step_limit_r;
    end
    if ((f_req == 7'd0) || (f_req > lim7)) begin
      num7 = lim7;
    end else begin
      num7 = f_req;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cls_nxt       = cls_r;
    nc_m1_nxt     = nc_m1_r;
    k_rd_nxt      = k_rd_r;
    nk_nxt        = nk_r;
    rd_v_nxt      = rd_v_r;
    out_v_nxt     = out_v_r && !out_tready;
    ans_nxt       = ans_r;
    ans_w_nxt     = ans_w_r;
    said_nxt      = said_r;
    col_nxt       = col_r;
    prod_nxt      = prod_r;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    out_class_nxt = out_class_r;
    out_score_nxt = out_score_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc && (f_op == OP_CLASSIFY)) begin
          state_nxt = S_MUL;
          cls_nxt   = '0;
          if (class_count_r == 4'd0) begin
            nc_m1_nxt = '0;
          end else if (int'(class_count_r) > MAX_CLASSES) begin
            nc_m1_nxt = CW'(MAX_CLASSES - 1);
          end else begin
            nc_m1_nxt = CW'(class_count_r - 4'd1);
          end
          if (int'(classifier_count_r) > MAX_CLASSIFIERS) begin
            nk_nxt = KCW'(MAX_CLASSIFIERS);
          end else begin
            nk_nxt = KCW'(classifier_count_r);
          end
          col_nxt   = test_mode_r ? '0 : SW'(num7 - 7'd1);
          ans_nxt   = f_ans;
          ans_w_nxt = f_ans;
          k_rd_nxt  = '0;
          rd_v_nxt  = 1'b0;
          prod_nxt  = ONE_Q32;
          best_nxt  = '0;
          best_idx_nxt = '0;
        end
      end
      S_MUL: begin
        // read of classifier k overlaps the multiply of classifier k-1
        if (rd_v_r) begin
          prod_nxt = mul_full[48:16];
        end
        if (tbl_re) begin
          k_rd_nxt  = k_rd_r + KCW'(1);
          rd_v_nxt  = 1'b1;
          said_nxt  = ans_w_r[0];
          ans_w_nxt = {1'b0, ans_w_r[31:1]};
        end else begin
          rd_v_nxt = 1'b0;
          if (!rd_v_r) begin
            state_nxt = S_PRIOR;
          end
        end
      end
      S_PRIOR: begin
        prod_nxt  = mul_full[48:16];
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (better) begin
          best_nxt     = prod_r;
          best_idx_nxt = cls_r;
        end
        if (cls_r == nc_m1_r) begin
          state_nxt = S_DONE;
        end else begin
          cls_nxt   = cls_r + CW'(1);
          prod_nxt  = ONE_Q32;
          k_rd_nxt  = '0;
          rd_v_nxt  = 1'b0;
          ans_w_nxt = ans_r;
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt     = 1'b1;
          out_class_nxt = 3'(best_idx_r);
          out_score_nxt = best_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      cls_r              <= '0;
      nc_m1_r            <= '0;
      k_rd_r             <= '0;
      nk_r               <= '0;
      rd_v_r             <= 1'b0;
      out_v_r            <= 1'b0;
      prod_r             <= '0;
      best_r             <= '0;
      best_idx_r         <= '0;
      class_count_r      <= 4'd2;
      classifier_count_r <= 6'd1;
      step_limit_r       <= 7'd1;
      test_mode_r        <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cls_r      <= cls_nxt;
      nc_m1_r    <= nc_m1_nxt;
      k_rd_r     <= k_rd_nxt;
      nk_r       <= nk_nxt;
      rd_v_r     <= rd_v_nxt;
      out_v_r    <= out_v_nxt;
      prod_r     <= prod_nxt;
      best_r     <= best_nxt;
      best_idx_r <= best_idx_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CLASS_COUNT:      class_count_r      <= cfg_data[3:0];
          CFG_CLASSIFIER_COUNT: classifier_count_r <= cfg_data[5:0];
          CFG_STEP_LIMIT:       step_limit_r       <= cfg_data;
          CFG_TEST_MODE:        test_mode_r        <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ans_r       <= ans_nxt;
    ans_w_r     <= ans_w_nxt;
    said_r      <= said_nxt;
    col_r       <= col_nxt;
    out_class_r <= out_class_nxt;
    out_score_r <= out_score_nxt;
  end

endmodule

`default_nettype wire

// ----- src/nbvd_checker.sv -----
// ----------------------------------------------------------------------------
// nbvd_checker
// Port-level checks on the vote decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "naive_bayes_vote_decoder_assert.svh"

module nbvd_checker
  import nbvd_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [1:0]             in_tuser,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;

  // stalled result holds
  `NBVD_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata), "result changed under stall")

  // score never above 1.0 in Q1.32
  `NBVD_ASSERT_NOW(a_score_max, out_tvalid, out_tdata[35:3] <= ONE_Q32, "score above one")

  // classify occupies the engine
  `NBVD_ASSERT_NEXT(a_busy, in_acc && (in_tuser == OP_CLASSIFY), !in_tready, "ready during classify")

  // writes and unused kinds produce no result
  `NBVD_ASSERT_NEXT(a_no_result, in_acc && (in_tuser != OP_CLASSIFY) && !out_tvalid, !out_tvalid, "result from a write")

endmodule

bind naive_bayes_vote_decoder nbvd_checker u_nbvd_checker (.*);

`default_nettype wire
